@@ rtl/xsr_pkg.sv @@
package xsr_pkg;

   localparam int WORD_W = 64;
   localparam int CNT_W  = $clog2(WORD_W);

   // splitmix64 constants
   localparam logic [WORD_W-1:0] SPLITMIX_GAMMA = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WORD_W-1:0] SPLITMIX_MUL1  = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_W-1:0] SPLITMIX_MUL2  = 64'h94D0_49BB_1331_11EB;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCRAMBLE,
      ST_DIV,
      ST_WRITE
   } item_state_type;

   typedef enum logic [2:0] {
      SM_IDLE,
      SM_ADD,
      SM_MUL1,
      SM_MIX2,
      SM_MUL2,
      SM_OUT
   } seed_state_type;

   typedef struct packed {
      logic              busy;
      logic              we;
      logic [1:0]        index;
      logic [WORD_W-1:0] data;
   } seed_write_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ rtl/xsr_seeder.sv @@
module xsr_seeder
   import xsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] seed,
   output seed_write_type    wr
);

   seed_state_type    state_ff, state_in;
   logic [WORD_W-1:0] counter_ff, counter_in;
   logic [WORD_W-1:0] mcand_ff, mcand_in;
   logic [WORD_W-1:0] mult_ff, mult_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]        idx_ff, idx_in;
   logic [WORD_W-1:0] sum;

   // reset value of the seed is zero, so reset starts a fill from zero
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SM_ADD;
         counter_ff <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         counter_ff <= counter_in;
         idx_ff     <= idx_in;
      end
      mcand_ff <= mcand_in;
      mult_ff  <= mult_in;
      acc_ff   <= acc_in;
      cnt_ff   <= cnt_in;
   end

   always_comb begin
      state_in   = state_ff;
      counter_in = counter_ff;
      mcand_in   = mcand_ff;
      mult_in    = mult_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      sum        = counter_ff + SPLITMIX_GAMMA;
      wr.busy    = (state_ff != SM_IDLE);
      wr.we      = 1'b0;
      wr.index   = idx_ff;
      wr.data    = acc_ff ^ (acc_ff >> 31);
      if (start) begin
         state_in   = SM_ADD;
         counter_in = seed;
         idx_in     = '0;
      end else begin
         unique case (state_ff)
            SM_IDLE: begin
            end
            SM_ADD: begin
               counter_in = sum;
               mcand_in   = sum ^ (sum >> 30);
               mult_in    = SPLITMIX_MUL1;
               acc_in     = '0;
               cnt_in     = '0;
               state_in   = SM_MUL1;
            end
            SM_MUL1, SM_MUL2: begin
               // shift-add multiply, one multiplier bit per cycle
               acc_in   = acc_ff + (mult_ff[0] ? mcand_ff : '0);
               mcand_in = {mcand_ff[WORD_W-2:0], 1'b0};
               mult_in  = {1'b0, mult_ff[WORD_W-1:1]};
               cnt_in   = cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(WORD_W - 1)) begin
                  state_in = (state_ff == SM_MUL1) ? SM_MIX2 : SM_OUT;
               end
            end
            SM_MIX2: begin
               mcand_in = acc_ff ^ (acc_ff >> 27);
               mult_in  = SPLITMIX_MUL2;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = SM_MUL2;
            end
            SM_OUT: begin
               wr.we    = 1'b1;
               idx_in   = idx_ff + 1'b1;
               state_in = (idx_ff == 2'd3) ? SM_IDLE : SM_ADD;
            end
            default: state_in = SM_IDLE;
         endcase
      end
   end

   // the fourth word ends the fill
   a_fill_ends: assert property (@(posedge clock) disable iff (reset)
      (wr.we && wr.index == 2'd3 && !start) |=> !wr.busy)
      else $error("seeder still busy after last word");

endmodule

@@ rtl/xsr_divider.sv @@
module xsr_divider
   import xsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] dividend,
   input  logic [WORD_W-1:0] divisor,
   output div_status_type    status,
   output logic [WORD_W-1:0] remainder
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] dividend_ff, dividend_in;
   logic [WORD_W-1:0] divisor_ff, divisor_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff      <= cnt_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   // restoring remainder, one dividend bit per cycle; a zero divisor
   // always subtracts nothing, which leaves the dividend itself
   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      cnt_in      = cnt_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      trial       = {rem_ff, dividend_ff[WORD_W-1]};
      diff        = trial - {1'b0, divisor_ff};
      if (start) begin
         busy_in     = 1'b1;
         cnt_in      = '0;
         dividend_in = dividend;
         divisor_in  = divisor;
         rem_in      = '0;
      end else if (busy_ff) begin
         rem_in      = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
         dividend_in = {dividend_ff[WORD_W-2:0], 1'b0};
         cnt_in      = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (done_ff && divisor_ff != '0) |-> (rem_ff < divisor_ff))
      else $error("remainder not below divisor");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("done without a running division");

endmodule

@@ rtl/xoshiro256ss_random_generator_core.sv @@
// xoshiro256** generator with splitmix64 seeding. After reset, and after
// every write of csr_wdata (csr_we high), the four 64-bit generator words are
// refilled from four splitmix64 outputs of the seed; the fill runs two
// bit-serial 64x64 multiplies per word, during which req_ready stays low
// (it is also low in the cycle of the write). Each item advances the
// generator once and returns the raw output and
// raw mod (high - low + 1) + low, modulo 2^64; a span that wraps to zero
// means the full range and gives raw + low. One item is in work at a
// time; its result comes from the bit-serial remainder unit that retires
// one dividend bit per cycle, and a new item is taken only once the
// previous result has gone into the output register. A result waits in
// the output register, and the next item is taken while it waits.
module xoshiro256ss_random_generator_core
   import xsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [WORD_W-1:0] req_range_low,
   input  logic [WORD_W-1:0] req_range_high,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_raw_value,
   output logic [WORD_W-1:0] rsp_ranged_value,
   // seed register
   input  logic              csr_we,
   input  logic [WORD_W-1:0] csr_wdata
);

   item_state_type    state_ff, state_in;
   logic [WORD_W-1:0] words_ff [4];
   logic [WORD_W-1:0] words_in [4];
   logic [WORD_W-1:0] mix_ff, mix_in;
   logic [WORD_W-1:0] raw_ff, raw_in;
   logic [WORD_W-1:0] low_ff, low_in;
   logic [WORD_W-1:0] span_ff, span_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_raw_ff, rsp_raw_in;
   logic [WORD_W-1:0] rsp_ranged_ff, rsp_ranged_in;

   // next-state terms of the generator
   logic [WORD_W-1:0] x2, x3, times5, scrambled;
   logic              accept;
   logic              div_start;

   seed_write_type    seed_wr;
   div_status_type    div_st;
   logic [WORD_W-1:0] div_rem;

   // splitmix64 fill of the generator words
   xsr_seeder u_seeder (
      .clock (clock),
      .reset (reset),
      .start (csr_we),
      .seed  (csr_wdata),
      .wr    (seed_wr)
   );

   // raw mod span, one bit per cycle
   xsr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (scrambled),
      .divisor   (span_ff),
      .status    (div_st),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      words_ff      <= words_in;
      mix_ff        <= mix_in;
      raw_ff        <= raw_in;
      low_ff        <= low_in;
      span_ff       <= span_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_ranged_ff <= rsp_ranged_in;
   end

   // no item is taken while the words are being refilled or a seed arrives
   assign req_ready = (state_ff == ST_IDLE) && !seed_wr.busy && !csr_we;
   assign accept    = req_valid && req_ready;

   // xoshiro256** update terms, all from the words before the step
   assign x2        = words_ff[2] ^ words_ff[0];
   assign x3        = words_ff[3] ^ words_ff[1];
   assign times5    = words_ff[1] + {words_ff[1][WORD_W-3:0], 2'b00};
   // second half of the scrambler: times 9
   assign scrambled = mix_ff + {mix_ff[WORD_W-4:0], 3'b000};

   always_comb begin
      state_in      = state_ff;
      words_in      = words_ff;
      mix_in        = mix_ff;
      raw_in        = raw_ff;
      low_in        = low_ff;
      span_in       = span_ff;
      div_start     = 1'b0;
      // result register drains on its own handshake
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_raw_in    = rsp_raw_ff;
      rsp_ranged_in = rsp_ranged_ff;

      if (seed_wr.we) begin
         words_in[seed_wr.index] = seed_wr.data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // rotl(w1 * 5, 7) now, times 9 next cycle
               mix_in      = {times5[WORD_W-8:0], times5[WORD_W-1:WORD_W-7]};
               words_in[0] = words_ff[0] ^ x3;
               words_in[1] = words_ff[1] ^ x2;
               words_in[2] = x2 ^ {words_ff[1][WORD_W-18:0], 17'd0};
               words_in[3] = {x3[WORD_W-46:0], x3[WORD_W-1:WORD_W-45]};
               low_in      = req_range_low;
               // zero span (full range) passes through the divider unchanged
               span_in     = req_range_high - req_range_low + 1'b1;
               state_in    = ST_SCRAMBLE;
            end
         end
         ST_SCRAMBLE: begin
            raw_in    = scrambled;
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_st.done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_raw_in    = raw_ff;
               rsp_ranged_in = div_rem + low_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_raw_value    = rsp_raw_ff;
   assign rsp_ranged_value = rsp_ranged_ff;

   // the divider only finishes while an item waits on it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == ST_DIV))
      else $error("divider done outside of division state");

   // an accepted item goes straight to the scrambler
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCRAMBLE && div_start))
      else $error("accepted item did not start scrambling");

   // a new result is only loaded when the previous one has left
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_WRITE))
      else $error("result overwritten before it was taken");

endmodule

@@ tb/sv/tb_xoshiro256ss_random_generator_core.sv @@
`timescale 1ns / 100ps

module tb_xoshiro256ss_random_generator_core;
   import xsr_pkg::*;

   // own copies of the splitmix64 constants
   localparam logic [63:0] MIX_GAMMA = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;
   localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] TOP_BIT   = 64'h8000_0000_0000_0000;

   // long receiver hold-off, enough to fill the block and stall its input
   localparam int HOLD_OFF_LEN = 400;
   // cycles allowed after the last result
   localparam int DRAIN_CYCLES = 250;
   localparam int MAX_REPORTED = 10;

   typedef struct {
      logic [WORD_W-1:0] raw;
      logic [WORD_W-1:0] ranged;
   } draw_type;

   // dut ports, all inputs known from time zero
   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [WORD_W-1:0] req_range_low  = '0;
   logic [WORD_W-1:0] req_range_high = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic [WORD_W-1:0] rsp_raw_value;
   logic [WORD_W-1:0] rsp_ranged_value;
   logic              csr_we         = 1'b0;
   logic [WORD_W-1:0] csr_wdata      = '0;

   // predictor state: the four generator words
   logic [WORD_W-1:0] gen_word [4];

   // draws accepted by the block and not yet returned, oldest first
   draw_type pending_draws [$];

   int mismatch_count = 0;

   // random idling control and the long hold-off on the result side
   bit idle_on        = 1'b0;
   bit hold_off_req   = 1'b0;
   int hold_off_count = 0;
   int ready_gap      = 0;

   xoshiro256ss_random_generator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_raw_value    (rsp_raw_value),
      .rsp_ranged_value (rsp_ranged_value),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   function automatic logic [63:0] rotl64(input logic [63:0] x, input int k);
      return (x << k) | (x >> (64 - k));
   endfunction

   // fill the generator words with four successive splitmix64 outputs
   function automatic void reseed_words(input logic [63:0] seed_value);
      logic [63:0] counter;
      logic [63:0] z;
      counter = seed_value;
      for (int i = 0; i < 4; i++) begin
         counter = counter + MIX_GAMMA;
         z = counter;
         z = (z ^ (z >> 30)) * MIX_MUL_A;
         z = (z ^ (z >> 27)) * MIX_MUL_B;
         gen_word[i] = z ^ (z >> 31);
      end
   endfunction

   // one generator step plus the range reduction
   function automatic draw_type predict_draw(input logic [63:0] low, input logic [63:0] high);
      draw_type    d;
      logic [63:0] shifted;
      logic [63:0] span;
      d.raw   = rotl64(gen_word[1] * 64'd5, 7) * 64'd9;
      shifted = gen_word[1] << 17;
      gen_word[2] = gen_word[2] ^ gen_word[0];
      gen_word[3] = gen_word[3] ^ gen_word[1];
      gen_word[1] = gen_word[1] ^ gen_word[2];
      gen_word[0] = gen_word[0] ^ gen_word[3];
      gen_word[2] = gen_word[2] ^ shifted;
      gen_word[3] = rotl64(gen_word[3], 45);
      span = high - low + 64'd1;
      // span wrapping to zero means the whole 64-bit space
      if (span == 64'd0)
         d.ranged = d.raw + low;
      else
         d.ranged = (d.raw % span) + low;
      return d;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // mix of range shapes: narrow, power of two, full, inverted, single value
   function automatic void pick_range(output logic [63:0] low, output logic [63:0] high);
      logic [63:0] a;
      logic [63:0] b;
      a = rand64();
      b = rand64();
      case ($urandom_range(0, 9))
         0: begin
            low  = a;
            high = b;
         end
         1: begin
            low  = a;
            high = a + 64'($urandom_range(0, 20));
         end
         2: begin
            low  = a;
            high = a + ((64'd1 << $urandom_range(1, 63)) - 64'd1);
         end
         3: begin
            // high one below low wraps the span to zero
            low  = a;
            high = a - 64'd1;
         end
         4: begin
            low  = 64'd0;
            high = ALL_ONES;
         end
         5: begin
            // inverted range
            low  = (a > b) ? a : b;
            high = (a > b) ? b : a;
         end
         6: begin
            low  = a;
            high = a;
         end
         7: begin
            low  = a;
            high = a + 64'($urandom);
         end
         8: begin
            low  = 64'($urandom_range(0, 255));
            high = ALL_ONES - 64'($urandom_range(0, 255));
         end
         default: begin
            low  = a;
            high = a + {16'd0, b[47:0]};
         end
      endcase
   endfunction

   // offer one item, keep valid up across back-to-back items
   task automatic send_draw_request(input logic [63:0] low, input logic [63:0] high);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_range_low  <= low;
      req_range_high <= high;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_draws.push_back(predict_draw(low, high));
   endtask

   task automatic send_random_draws(input int count);
      logic [63:0] low;
      logic [63:0] high;
      repeat (count) begin
         pick_range(low, high);
         send_draw_request(low, high);
      end
   endtask

   task automatic wait_all_returned();
      req_valid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
   endtask

   // seed write only once the block is drained and ready
   task automatic load_seed(input logic [63:0] seed_value);
      wait_all_returned();
      while (!req_ready) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= seed_value;
      @(posedge clock);
      csr_we    <= 1'b0;
      reseed_words(seed_value);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // field extremes, full range both ways, inverted and single-value ranges
   task automatic test_range_extremes();
      send_draw_request(64'd0, 64'd0);
      send_draw_request(64'd0, ALL_ONES);
      send_draw_request(ALL_ONES, ALL_ONES);
      send_draw_request(ALL_ONES, ALL_ONES - 64'd1);
      send_draw_request(64'd1, 64'd0);
      send_draw_request(64'd0, ALL_ONES - 64'd1);
      send_draw_request(64'd5, 64'd2);
      send_draw_request(ALL_ONES, 64'd0);
      send_draw_request(64'd0, 64'd1);
      send_draw_request(64'd0, TOP_BIT - 64'd1);
      send_draw_request(TOP_BIT, ALL_ONES);
      send_draw_request(TOP_BIT, TOP_BIT - 64'd1);
      send_draw_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      send_draw_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
   endtask

   // reseed with extreme and random values, a few draws after each
   task automatic test_seed_register();
      logic [63:0] seeds [6];
      seeds[0] = ALL_ONES;
      seeds[1] = 64'd0;
      seeds[2] = 64'd1;
      seeds[3] = TOP_BIT;
      seeds[4] = rand64();
      seeds[5] = rand64();
      foreach (seeds[i]) begin
         load_seed(seeds[i]);
         send_random_draws(8);
      end
   endtask

   // result side holds off while items keep coming, input must stall
   task automatic test_output_backpressure();
      hold_off_req <= 1'b1;
      send_random_draws(8);
      while (hold_off_count < HOLD_OFF_LEN) @(posedge clock);
      hold_off_req <= 1'b0;
   endtask

   task automatic test_random_ranges();
      repeat (4) begin
         load_seed(rand64());
         send_random_draws(400);
      end
   endtask

   // last part of the run with no idling on either side
   task automatic test_streaming_no_idle();
      idle_on <= 1'b0;
      send_random_draws(120);
   endtask

   // ------------------------------------------------------------------
   // result side: random ready bursts plus the long hold-off
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (!hold_off_req)
         hold_off_count <= 0;
      if (hold_off_req && hold_off_count < HOLD_OFF_LEN) begin
         rsp_ready      <= 1'b0;
         hold_off_count <= hold_off_count + 1;
      end else if (ready_gap != 0) begin
         rsp_ready <= 1'b0;
         ready_gap <= ready_gap - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         // start a burst with ready held low
         rsp_ready <= 1'b0;
         ready_gap <= $urandom_range(0, 10);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare every returned item with the oldest pending draw
   always @(posedge clock) begin
      draw_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_draws.size() == 0) begin
            if (mismatch_count < MAX_REPORTED)
               $display("%0t: result raw %h ranged %h with nothing pending",
                        $time, rsp_raw_value, rsp_ranged_value);
            mismatch_count++;
         end else begin
            want = pending_draws.pop_front();
            if (rsp_raw_value !== want.raw) begin
               if (mismatch_count < MAX_REPORTED)
                  $display("%0t: raw_value expected %h got %h",
                           $time, want.raw, rsp_raw_value);
               mismatch_count++;
            end
            if (rsp_ranged_value !== want.ranged) begin
               if (mismatch_count < MAX_REPORTED)
                  $display("%0t: ranged_value expected %h got %h",
                           $time, want.ranged, rsp_ranged_value);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      // words after reset come from seed 0
      reseed_words(64'd0);
      repeat (10) @(posedge clock);
      reset   <= 1'b0;
      idle_on <= 1'b1;

      test_range_extremes();
      test_seed_register();
      test_output_backpressure();
      test_random_ranges();
      test_streaming_no_idle();

      wait_all_returned();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_draws.size() == 0) begin
         $display("tb_xoshiro256ss_random_generator_core: PASS");
      end else begin
         if (pending_draws.size() != 0)
            $display("%0d results never returned", pending_draws.size());
         $display("tb_xoshiro256ss_random_generator_core: FAIL");
      end
      $finish;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("timeout with %0d results pending", pending_draws.size());
      $display("tb_xoshiro256ss_random_generator_core: FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/xsr_pkg.sv
rtl/xsr_seeder.sv
rtl/xsr_divider.sv
rtl/xoshiro256ss_random_generator_core.sv
tb/sv/tb_xoshiro256ss_random_generator_core.sv
